// ===== rtl/gf2n_arith_unit_defines.svh =====
// assertion macros for the gf2n arithmetic unit
`ifndef GF2N_ARITH_UNIT_DEFINES_SVH
`define GF2N_ARITH_UNIT_DEFINES_SVH

// consequent must hold in the same cycle
`define GFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the following cycle
`define GFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gfa_pkg.sv =====
package gfa_pkg;

  // field geometry
  localparam int FIELD_DEGREE = 8;
  localparam int ELEM_W       = FIELD_DEGREE;
  localparam int WIDE_W       = FIELD_DEGREE + 1;
  localparam int POLY_W       = 9;
  localparam int EXP_W        = 32;
  localparam int KIND_W       = 3;
  localparam int CNT_W        = (FIELD_DEGREE > 1) ? $clog2(FIELD_DEGREE) : 1;

  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(FIELD_DEGREE - 1);
  localparam logic [POLY_W-1:0] POLY_RESET = 9'd283;
  // exponent for inversion: 2^n - 2
  localparam logic [EXP_W-1:0]  INV_EXP    = EXP_W'((64'd1 << FIELD_DEGREE) - 64'd2);
  localparam logic [WIDE_W-1:0] WIDE_ONE   = WIDE_W'(1);

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD = 3'd0,
    KIND_MUL = 3'd1,
    KIND_DIV = 3'd2,
    KIND_POW = 3'd3,
    KIND_INV = 3'd4
  } kind_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW_TEST,
    ST_POW_RUN,
    ST_MUL_LOAD,
    ST_MUL_RUN
  } state_e;

  // control for the bit-serial multipliers
  typedef struct packed {
    logic load;
    logic step;
  } mul_ctrl_t;

endpackage

// ===== rtl/gfa_mul.sv =====
module gfa_mul (
  input  logic                            clk_i,
  input  gfa_pkg::mul_ctrl_t              ctrl_i,
  input  logic [gfa_pkg::WIDE_W-1:0]      poly_i,
  input  logic [gfa_pkg::WIDE_W-1:0]      a_i,
  input  logic [gfa_pkg::ELEM_W-1:0]      b_i,
  output logic [gfa_pkg::WIDE_W-1:0]      prod_o
);

  logic [gfa_pkg::WIDE_W-1:0] part_q, part_d, part_shl;
  logic [gfa_pkg::ELEM_W-1:0] bsh_q;
  logic [gfa_pkg::WIDE_W-1:0] prod_q, prod_d;

  // one bit of b per cycle while step is high: add partial, then shift and reduce
  always_comb begin
    part_shl = {part_q[gfa_pkg::WIDE_W-2:0], 1'b0};
    part_d   = part_shl[gfa_pkg::WIDE_W-1] ? (part_shl ^ poly_i) : part_shl;
    prod_d   = bsh_q[0] ? (prod_q ^ part_q) : prod_q;
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      part_q <= a_i;
      bsh_q  <= b_i;
      prod_q <= '0;
    end else if (ctrl_i.step) begin
      part_q <= part_d;
      bsh_q  <= bsh_q >> 1;
      prod_q <= prod_d;
    end
  end

  // product including the bit taken in this cycle
  assign prod_o = prod_d;

endmodule

// ===== rtl/gf2n_arith_unit.sv =====
// channel   | direction | signals                                      | handshake
// ----------+-----------+----------------------------------------------+-----------------------
// command   | in        | kind_i operand_a_i operand_b_i exponent_i    | start_i high, busy_o low
// result    | out       | result_o                                     | result_valid_o, 1 cycle
// config    | in        | cfg_reduction_poly_i                         | cfg_valid_i, cfg_ready_o
//
// add and unused kinds: result in the cycle after the command word
// multiply: a load state, then a run state; each field multiply steps one bit of b per cycle
// power: test and run states for each exponent bit up to its top set bit, then a last test
// inverse: a power with exponent 2^n - 2; divide: inverse plus one multiply
// reset clears the sequencer and loads the polynomial 0x11b; no clearing pass
// results cannot be stalled; busy_o holds commands off while an operation runs
`include "gf2n_arith_unit_defines.svh"

module gf2n_arith_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [gfa_pkg::KIND_W-1:0]      kind_i,
  input  logic [gfa_pkg::ELEM_W-1:0]      operand_a_i,
  input  logic [gfa_pkg::ELEM_W-1:0]      operand_b_i,
  input  logic [gfa_pkg::EXP_W-1:0]       exponent_i,
  output logic                            result_valid_o,
  output logic [gfa_pkg::ELEM_W-1:0]      result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gfa_pkg::POLY_W-1:0]      cfg_reduction_poly_i
);

  gfa_pkg::state_e state_q, state_d;
  gfa_pkg::mul_ctrl_t mul_ctrl;

  logic [gfa_pkg::POLY_W-1:0] poly_q;
  logic [gfa_pkg::CNT_W-1:0]  cnt_q;
  logic                       div_q;
  logic [gfa_pkg::WIDE_W-1:0] opa_q, acc_q, base_q;
  logic [gfa_pkg::EXP_W-1:0]  exp_q;
  logic [gfa_pkg::ELEM_W-1:0] result_q;
  logic                       valid_q;

  logic                       accept, last, exp_zero;
  logic                       pow_upd, fin_pow, fin_mul;
  logic [gfa_pkg::WIDE_W-1:0] m1_a, m1_prod, m2_prod;
  logic [gfa_pkg::ELEM_W-1:0] m1_b;
  logic                       add_acc, mul_acc, mul_end, pow_run, res_idle;

  assign busy_o      = (state_q != gfa_pkg::ST_IDLE);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign last        = (cnt_q == '0);
  assign exp_zero    = (exp_q == '0);

  // polynomial register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= gfa_pkg::POLY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poly_q <= cfg_reduction_poly_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gfa_pkg::ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            gfa_pkg::KIND_MUL: state_d = gfa_pkg::ST_MUL_LOAD;
            gfa_pkg::KIND_DIV,
            gfa_pkg::KIND_POW,
            gfa_pkg::KIND_INV: state_d = gfa_pkg::ST_POW_TEST;
            default:           state_d = gfa_pkg::ST_IDLE;
          endcase
        end
      end
      gfa_pkg::ST_POW_TEST: begin
        if (!exp_zero) begin
          state_d = gfa_pkg::ST_POW_RUN;
        end else if (div_q) begin
          state_d = gfa_pkg::ST_MUL_LOAD;
        end else begin
          state_d = gfa_pkg::ST_IDLE;
        end
      end
      gfa_pkg::ST_POW_RUN: begin
        if (last) state_d = gfa_pkg::ST_POW_TEST;
      end
      gfa_pkg::ST_MUL_LOAD: state_d = gfa_pkg::ST_MUL_RUN;
      gfa_pkg::ST_MUL_RUN: begin
        if (last) state_d = gfa_pkg::ST_IDLE;
      end
      default: state_d = gfa_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_ctrl.load = 1'b0;
    mul_ctrl.step = 1'b0;
    pow_upd       = 1'b0;
    fin_pow       = 1'b0;
    fin_mul       = 1'b0;
    case (state_q)
      gfa_pkg::ST_POW_TEST: begin
        mul_ctrl.load = !exp_zero;
        fin_pow       = exp_zero && !div_q;
      end
      gfa_pkg::ST_POW_RUN: begin
        mul_ctrl.step = 1'b1;
        pow_upd       = last;
      end
      gfa_pkg::ST_MUL_LOAD: mul_ctrl.load = 1'b1;
      gfa_pkg::ST_MUL_RUN: begin
        mul_ctrl.step = 1'b1;
        fin_mul       = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gfa_pkg::ST_IDLE;
      cnt_q   <= '0;
      div_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_ctrl.load) begin
        cnt_q <= gfa_pkg::CNT_LAST;
      end else if (mul_ctrl.step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (accept) div_q <= (kind_i == gfa_pkg::KIND_DIV);
    end
  end

  // multiplier operands: acc*base in power steps, a*acc for the final multiply
  assign m1_a = (state_q == gfa_pkg::ST_MUL_LOAD) ? opa_q : acc_q;
  assign m1_b = (state_q == gfa_pkg::ST_MUL_LOAD) ? acc_q[gfa_pkg::ELEM_W-1:0]
                                                  : base_q[gfa_pkg::ELEM_W-1:0];

  gfa_mul u_mul_acc (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .poly_i (poly_q[gfa_pkg::WIDE_W-1:0]),
    .a_i    (m1_a),
    .b_i    (m1_b),
    .prod_o (m1_prod)
  );

  // squaring unit runs alongside
  gfa_mul u_mul_sq (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .poly_i (poly_q[gfa_pkg::WIDE_W-1:0]),
    .a_i    (base_q),
    .b_i    (base_q[gfa_pkg::ELEM_W-1:0]),
    .prod_o (m2_prod)
  );

  // operand and power registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      opa_q <= {1'b0, operand_a_i};
      exp_q <= exponent_i;
      case (kind_i)
        gfa_pkg::KIND_MUL: begin
          acc_q <= {1'b0, operand_b_i};
        end
        gfa_pkg::KIND_DIV: begin
          acc_q  <= gfa_pkg::WIDE_ONE;
          base_q <= {1'b0, operand_b_i};
          exp_q  <= gfa_pkg::INV_EXP;
        end
        gfa_pkg::KIND_INV: begin
          acc_q  <= gfa_pkg::WIDE_ONE;
          base_q <= {1'b0, operand_a_i};
          exp_q  <= gfa_pkg::INV_EXP;
        end
        default: begin
          acc_q  <= gfa_pkg::WIDE_ONE;
          base_q <= {1'b0, operand_a_i};
        end
      endcase
    end else if (pow_upd) begin
      if (exp_q[0]) acc_q <= m1_prod;
      base_q <= m2_prod;
      exp_q  <= exp_q >> 1;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= (kind_i == gfa_pkg::KIND_ADD) ? (operand_a_i ^ operand_b_i) : '0;
    end else if (fin_pow) begin
      result_q <= acc_q[gfa_pkg::ELEM_W-1:0];
    end else if (fin_mul) begin
      result_q <= m1_prod[gfa_pkg::ELEM_W-1:0];
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= fin_pow || fin_mul ||
                 (accept && (state_d == gfa_pkg::ST_IDLE));
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

  // terms for the checks
  assign add_acc  = accept && (kind_i == gfa_pkg::KIND_ADD);
  assign mul_acc  = accept && (kind_i == gfa_pkg::KIND_MUL);
  assign mul_end  = (state_q == gfa_pkg::ST_MUL_RUN) && last;
  assign pow_run  = (state_q == gfa_pkg::ST_POW_RUN);
  assign res_idle = result_valid_o && !busy_o;

  // checks
  `GFA_ASSERT_NEXT(a_add_one_cycle, add_acc, res_idle, "add did not finish in one cycle")
  `GFA_ASSERT_NEXT(a_mul_busy, mul_acc, busy_o && !result_valid_o, "multiply did not start")
  `GFA_ASSERT_NOW(a_pow_exp_live, pow_run, !exp_zero, "power step with zero exponent")
  `GFA_ASSERT_NEXT(a_mul_done, mul_end, res_idle, "multiply end without result")

endmodule
